[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL. They vanish when SYNTH is defined.
// Both macros expect the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BPK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: property failed");
`define BPK_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define BPK_ASSERT(lbl, prop)
`define BPK_NEVER(lbl, cond)
`endif
`endif

[hw/rtl/bpk_pkg.sv]
package bpk_pkg;

    localparam int EST_W   = 31;
    localparam int COEF_W  = 32;
    localparam int RHS_W   = 32;
    localparam int COL_W   = 12;
    localparam int DIFF_W  = 63;
    localparam int SWEEP_W = 32;
    localparam int REC_W   = 9;
    localparam int Q_W     = 32;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [EST_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [Q_W-1:0]   Q_SAT   = 32'h8000_0000;
    localparam logic [REC_W-1:0] REC_MAX = 9'd511;

    localparam int DEF_MAX_COLUMNS      = 4096;
    localparam int DEF_MAX_ROW_NONZEROS = 64;

    // Divider widths for the default row length, mirrored from the top level.
    localparam int DEF_NORM_W     = 47 + $clog2(DEF_MAX_ROW_NONZEROS + 1);
    localparam int DEF_DOTMAG_W   = 40 + $clog2(DEF_MAX_ROW_NONZEROS + 1);
    localparam int DEF_R_W        = ((DEF_DOTMAG_W + 1 > 48) ? DEF_DOTMAG_W + 1 : 48) + 1;
    localparam int DEF_DIVIDEND_W = DEF_R_W - 1 + COEF_W + 6;

    typedef enum logic [1:0] {
        REQ_NZ    = 2'd0,
        REQ_SWEEP = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_NORM = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_UNUSED    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SWEEPS = 2'd0,
        CFG_PLATEAU    = 2'd1,
        CFG_ACTIVE     = 2'd2,
        CFG_NONE       = 2'd3
    } t_cfg_idx;

endpackage

[hw/rtl/bpk_div.sv]
`include "assert_macros.svh"

module bpk_div #(
    parameter int DIVIDEND_W = bpk_pkg::DEF_DIVIDEND_W,
    parameter int DIVISOR_W  = bpk_pkg::DEF_NORM_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DIVIDEND_W-1:0]  i_dividend,
    input  logic [DIVISOR_W-1:0]   i_divisor,
    output logic                   o_done,
    output logic [bpk_pkg::Q_W-1:0] o_quotient
);
    import bpk_pkg::*;

    // Quotients of 2^31 and above saturate, so 31 restoring steps suffice.
    localparam int STEPS = Q_W - 1;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int CMP_W = (DIVIDEND_W > DIVISOR_W) ? DIVIDEND_W : DIVISOR_W;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_sat;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_d;
    logic [STEPS-1:0]     r_low;
    logic [STEPS-1:0]     r_q;

    logic                 sat;
    logic [DIVISOR_W:0]   rem2;
    logic [DIVISOR_W:0]   rem_sub;
    logic                 ge;

    always_comb begin
        sat     = CMP_W'(i_dividend >> STEPS) >= CMP_W'(i_divisor);
        rem2    = {r_rem, r_low[STEPS-1]};
        ge      = rem2 >= {1'b0, r_d};
        rem_sub = rem2 - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_d   <= i_divisor;
                r_sat <= sat;
                r_rem <= DIVISOR_W'(i_dividend >> STEPS);
                r_low <= i_dividend[STEPS-1:0];
                r_q   <= '0;
                if (sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(STEPS);
                end
            end else if (r_busy) begin
                r_rem <= ge ? DIVISOR_W'(rem_sub) : DIVISOR_W'(rem2);
                r_low <= {r_low[STEPS-2:0], 1'b0};
                r_q   <= {r_q[STEPS-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sat ? Q_SAT : {1'b0, r_q};

    `BPK_ASSERT(a_q_bound, o_done |-> (o_quotient <= Q_SAT))
    `BPK_NEVER(a_start_busy, i_start && r_busy)
    `BPK_ASSERT(a_done_pulse, o_done |=> !o_done)

endmodule

[hw/rtl/box_projected_kaczmarz_solver.sv]
// A nonzero that does not close its row goes straight to the result register; a row end runs
// a norm and dot pass over the buffered row and, unless the norm or the residual is zero, an
// update pass that uses the 31-step serial divider once per nonzero coefficient. End of sweep
// walks the active columns, again when the midpoint is snapshot; a clear zeroes them.
// One request is in flight at a time; the output register lets the next request in early.
// Reset is synchronous, active low; afterwards a clearing pass over all MAX_COLUMNS columns runs.
`include "assert_macros.svh"

module box_projected_kaczmarz_solver #(
    parameter int MAX_COLUMNS      = bpk_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROW_NONZEROS = bpk_pkg::DEF_MAX_ROW_NONZEROS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, lowest bit up: column[11:0], coefficient[43:12], rhs[75:44], zero pad[79:76]
    input  logic [bpk_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser, lowest bit up: req_type[1:0], estimate_sel[2]
    input  logic [bpk_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // tlast: last_in_row
    input  logic                            s_axis_tlast,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, lowest bit up: sweep_diff[62:0], solution_value[93:63], converged[94],
    // sweeps_done[126:95], zero pad[127]
    output logic [bpk_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: status[1:0]
    output logic [bpk_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    // Configuration writes.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bpk_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpk_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bpk_pkg::*;

    // Address, walk and row-buffer widths.
    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int LW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = (MAX_ROW_NONZEROS > 1) ? $clog2(MAX_ROW_NONZEROS) : 1;
    localparam int FW = $clog2(MAX_ROW_NONZEROS + 2);
    localparam int BW = AW + COEF_W;
    localparam int EW = 2 * EST_W;

    // Arithmetic widths. Each |c|*x >> 22 stays below 2^40 and each c*c >> 16 below 2^47.
    localparam int NORM_W   = 47 + $clog2(MAX_ROW_NONZEROS + 1);
    localparam int DOTMAG_W = 40 + $clog2(MAX_ROW_NONZEROS + 1);
    localparam int DOT_W    = DOTMAG_W + 1;
    localparam int R_W      = ((DOT_W > 48) ? DOT_W : 48) + 1;
    localparam int RM_W     = R_W - 1;
    localparam int HALF     = (RM_W + 1) / 2;
    localparam int PLO_W    = HALF + COEF_W;
    localparam int PHI_W    = RM_W - HALF + COEF_W;
    localparam int PROD_W   = RM_W + COEF_W;
    localparam int PW       = PROD_W + 6;
    localparam int PM_W     = COEF_W + EST_W;
    localparam int SQ_W     = 2 * EST_W - 12;

    // The sequencer. Walk states issue one memory address per cycle; the row states
    // step through the row buffer one nonzero at a time.
    typedef enum logic [17:0] {
        S_CLR    = 18'h00001,
        S_IDLE   = 18'h00002,
        S_OUT    = 18'h00004,
        S_DOT_A  = 18'h00008,
        S_DOT_B  = 18'h00010,
        S_DOT_C  = 18'h00020,
        S_DOT_D  = 18'h00040,
        S_RES    = 18'h00080,
        S_UPD_A  = 18'h00100,
        S_UPD_B  = 18'h00200,
        S_UPD_C  = 18'h00400,
        S_UPD_D  = 18'h00800,
        S_UPD_E  = 18'h01000,
        S_SWEEP  = 18'h02000,
        S_SW_DEC = 18'h04000,
        S_SNAP   = 18'h08000,
        S_RD_A   = 18'h10000,
        S_RD_B   = 18'h20000
    } t_state;

    // Columns at or above MAX_COLUMNS fold back by repeated subtraction of shifted copies.
    function automatic logic [AW-1:0] fold_col(input logic [COL_W-1:0] c);
        logic [COL_W-1:0] v;
        v = c;
        for (int j = COL_W - 1; j >= 0; j--) begin
            if ((MAX_COLUMNS << j) < (1 << COL_W)) begin
                if (v >= COL_W'(MAX_COLUMNS << j)) begin
                    v = v - COL_W'(MAX_COLUMNS << j);
                end
            end
        end
        return AW'(v);
    endfunction

    // Memories. The estimate memory holds both vectors side by side: the upward estimate
    // in the upper half of each word and the downward estimate in the lower half.
    logic [EW-1:0]    est_mem [MAX_COLUMNS];
    logic [EST_W-1:0] mid_mem [MAX_COLUMNS];
    logic [BW-1:0]    buf_mem [MAX_ROW_NONZEROS];

    logic [EW-1:0]    est_rdata;
    logic [EST_W-1:0] mid_rdata;
    logic [BW-1:0]    buf_rdata;

    logic             est_we;
    logic [AW-1:0]    est_raddr;
    logic [AW-1:0]    est_waddr;
    logic [EW-1:0]    est_wdata;
    logic             mid_we;
    logic [AW-1:0]    mid_raddr;
    logic [AW-1:0]    mid_waddr;
    logic [EST_W-1:0] mid_wdata;
    logic             buf_we;
    logic [RW-1:0]    buf_waddr;
    logic [BW-1:0]    buf_wdata;

    // Control and configuration state.
    t_state             r_state;
    logic               r_init;
    logic [15:0]        r_min_sweeps;
    logic [7:0]         r_plateau;
    logic [12:0]        r_active;
    logic [FW-1:0]      r_fill;
    logic [SWEEP_W-1:0] r_sweeps;
    logic [DIFF_W-1:0]  r_ref;
    logic [REC_W-1:0]   r_rec;
    logic               r_done;

    // Request held while it is worked on.
    logic [AW-1:0]      r_col;
    logic               r_sel;
    logic [RHS_W-1:0]   r_rhs;
    logic [FW-1:0]      r_n;
    logic [RW-1:0]      r_k;
    logic [LW-1:0]      r_len;
    logic [LW-1:0]      r_idx;
    logic [AW-1:0]      r_a1;
    logic               r_v1;
    logic               r_v2;

    // Projection datapath.
    logic [COEF_W-1:0]  r_coef;
    logic               r_cneg;
    logic [PM_W-1:0]    r_pm;
    logic [63:0]        r_pn;
    logic [NORM_W-1:0]  r_norm;
    logic signed [DOT_W-1:0] r_dot;
    logic               r_rneg;
    logic [RM_W-1:0]    r_rmag;
    logic [PLO_W-1:0]   r_plo;
    logic [PHI_W-1:0]   r_phi;
    logic [EST_W-1:0]   r_x;
    logic [EW-1:0]      r_word;
    logic [Q_W-1:0]     r_q;

    // Sweep datapath and pending result.
    logic [SQ_W-1:0]    r_sq;
    logic [DIFF_W-1:0]  r_acc;
    t_status            r_rstatus;
    logic [EST_W-1:0]   r_rsol;

    // Output register.
    logic               r_ov;
    t_status            r_ostatus;
    logic [DIFF_W-1:0]  r_odiff;
    logic [EST_W-1:0]   r_osol;
    logic               r_oconv;
    logic [SWEEP_W-1:0] r_osweeps;

    // Combinational helpers.
    logic               s_acc;
    t_req               req;
    logic [AW-1:0]      in_col;
    logic [FW-1:0]      fill_next;
    logic [LW-1:0]      walk_len;
    logic               last_k;
    logic [AW-1:0]      buf_col;
    logic [COEF_W-1:0]  buf_coef;
    logic [COEF_W-1:0]  buf_cm;
    logic [EST_W-1:0]   est_up;
    logic [EST_W-1:0]   est_dn;
    logic [EST_W-1:0]   est_x;
    logic [COEF_W-1:0]  coef_m;
    logic [40:0]        dot_p;
    logic signed [DOT_W-1:0] dot_part;
    logic signed [47:0] rhs_sh;
    logic signed [R_W-1:0] resid;
    logic [EST_W-1:0]   est_d;
    logic [2*EST_W-1:0] est_d2;
    logic [63:0]        acc_sum;
    logic [PROD_W-1:0]  prod;
    logic [PW-1:0]      dividend;
    logic               div_start;
    logic               div_done;
    logic [Q_W-1:0]     div_q;
    logic [EST_W+1:0]   x_up;
    logic [EST_W-1:0]   x_new;
    logic [REC_W-1:0]   rec_inc;
    logic [EST_W:0]     mid_sum;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        req       = t_req'(s_axis_tuser[1:0]);
        in_col    = fold_col(s_axis_tdata[COL_W-1:0]);
        fill_next = (r_fill < FW'(MAX_ROW_NONZEROS)) ? r_fill + 1'b1
                                                      : FW'(MAX_ROW_NONZEROS + 1);
        if (32'(r_active) > 32'(MAX_COLUMNS)) begin
            walk_len = LW'(MAX_COLUMNS);
        end else begin
            walk_len = LW'(r_active);
        end
        last_k   = (FW'(r_k) == r_n - 1'b1);
        buf_col  = buf_rdata[BW-1:COEF_W];
        buf_coef = buf_rdata[COEF_W-1:0];
        buf_cm   = buf_coef[COEF_W-1] ? (~buf_coef + 1'b1) : buf_coef;
        est_up   = est_rdata[EW-1:EST_W];
        est_dn   = est_rdata[EST_W-1:0];
        est_x    = r_sel ? est_up : est_dn;
        coef_m   = r_coef[COEF_W-1] ? (~r_coef + 1'b1) : r_coef;

        // Dot product term, truncated toward zero before the sign is applied.
        dot_p    = r_pm[PM_W-1:22];
        dot_part = r_cneg ? -DOT_W'(dot_p) : DOT_W'(dot_p);

        // Residual in Q16.32.
        rhs_sh = {r_rhs, 16'b0};
        resid  = R_W'(rhs_sh) - R_W'(r_dot);

        // Sweep difference term and its saturating sum.
        est_d   = (est_up >= est_dn) ? est_up - est_dn : est_dn - est_up;
        est_d2  = est_d * est_d;
        acc_sum = {1'b0, r_acc} + 64'(r_sq);

        // |r|*|c| from the two registered partial products, scaled by 2^6.
        prod      = (PROD_W'(r_phi) << HALF) + PROD_W'(r_plo);
        dividend  = {prod, 6'b0};
        div_start = (r_state == S_UPD_C);

        // Clamped update of one estimate element.
        x_up = {2'b0, r_x} + {1'b0, r_q};
        if (r_rneg != r_cneg) begin
            x_new = (r_q >= {1'b0, r_x}) ? '0 : r_x - EST_W'(r_q);
        end else begin
            x_new = (x_up > (EST_W + 2)'(ONE_Q30)) ? ONE_Q30 : EST_W'(x_up);
        end

        rec_inc = (r_rec == REC_MAX) ? r_rec : r_rec + 1'b1;
        mid_sum = {1'b0, est_up} + {1'b0, est_dn};
    end

    // Memory port control.
    always_comb begin
        est_we    = 1'b0;
        est_raddr = r_idx[AW-1:0];
        est_waddr = r_idx[AW-1:0];
        est_wdata = '0;
        mid_we    = 1'b0;
        mid_raddr = r_col;
        mid_waddr = r_idx[AW-1:0];
        mid_wdata = '0;
        buf_we    = s_acc && (req == REQ_NZ) && (r_fill < FW'(MAX_ROW_NONZEROS));
        buf_waddr = r_fill[RW-1:0];
        buf_wdata = {in_col, s_axis_tdata[COL_W+COEF_W-1:COL_W]};
        case (r_state)
            S_CLR: begin
                est_we = (r_idx < r_len);
                mid_we = (r_idx < r_len);
            end
            S_DOT_B, S_UPD_B: begin
                est_raddr = buf_col;
            end
            S_UPD_E: begin
                est_we    = 1'b1;
                est_waddr = r_col;
                est_wdata = r_sel ? {x_new, r_word[EST_W-1:0]} : {r_word[EW-1:EST_W], x_new};
            end
            S_SNAP: begin
                mid_we    = r_v1;
                mid_waddr = r_a1;
                mid_wdata = mid_sum[EST_W:1];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (est_we) begin
            est_mem[est_waddr] <= est_wdata;
        end
        est_rdata <= est_mem[est_raddr];
        if (mid_we) begin
            mid_mem[mid_waddr] <= mid_wdata;
        end
        mid_rdata <= mid_mem[mid_raddr];
        if (buf_we) begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata <= buf_mem[r_k];
    end

    bpk_div #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (NORM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_norm),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_init       <= 1'b1;
            r_idx        <= '0;
            r_len        <= LW'(MAX_COLUMNS);
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_min_sweeps <= '0;
            r_plateau    <= 8'd10;
            r_active     <= 13'd4096;
            r_fill       <= '0;
            r_sweeps     <= '0;
            r_ref        <= '0;
            r_rec        <= '0;
            r_done       <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MIN_SWEEPS: r_min_sweeps <= i_cfg_data;
                    CFG_PLATEAU:    r_plateau    <= i_cfg_data[7:0];
                    CFG_ACTIVE:     r_active     <= i_cfg_data[12:0];
                    default: begin
                    end
                endcase
            end

            if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                // Zeroing walk, used after reset and for clear requests.
                S_CLR: begin
                    if (r_idx < r_len) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_OUT;
                    end
                end

                S_IDLE: begin
                    if (s_acc) begin
                        r_acc     <= '0;
                        r_rstatus <= ST_OK;
                        r_rsol    <= '0;
                        r_col     <= in_col;
                        r_sel     <= s_axis_tuser[2];
                        r_rhs     <= s_axis_tdata[COL_W+COEF_W+RHS_W-1:COL_W+COEF_W];
                        r_idx     <= '0;
                        r_v1      <= 1'b0;
                        r_v2      <= 1'b0;
                        r_len     <= walk_len;
                        case (req)
                            REQ_NZ: begin
                                if (s_axis_tlast) begin
                                    r_fill <= '0;
                                    r_n    <= fill_next;
                                    r_k    <= '0;
                                    r_norm <= '0;
                                    r_dot  <= '0;
                                    if (fill_next > FW'(MAX_ROW_NONZEROS)) begin
                                        r_rstatus <= ST_TOO_LONG;
                                        r_state   <= S_OUT;
                                    end else begin
                                        r_state <= S_DOT_A;
                                    end
                                end else begin
                                    r_fill  <= fill_next;
                                    r_state <= S_OUT;
                                end
                            end
                            REQ_SWEEP: begin
                                if (r_sweeps != '1) begin
                                    r_sweeps <= r_sweeps + 1'b1;
                                end
                                r_state <= S_SWEEP;
                            end
                            REQ_READ: begin
                                r_state <= S_RD_A;
                            end
                            REQ_CLEAR: begin
                                r_fill   <= '0;
                                r_sweeps <= '0;
                                r_ref    <= '0;
                                r_rec    <= '0;
                                r_done   <= 1'b0;
                                r_state  <= S_CLR;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end

                // The result waits here until the output register is free.
                S_OUT: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov      <= 1'b1;
                        r_ostatus <= r_rstatus;
                        r_odiff   <= r_acc;
                        r_osol    <= r_rsol;
                        r_oconv   <= r_done;
                        r_osweeps <= r_sweeps;
                        r_state   <= S_IDLE;
                    end
                end

                // Norm and dot product pass over the buffered row.
                S_DOT_A: r_state <= S_DOT_B;
                S_DOT_B: begin
                    r_coef  <= buf_coef;
                    r_state <= S_DOT_C;
                end
                S_DOT_C: begin
                    r_pm    <= coef_m * est_x;
                    r_pn    <= coef_m * coef_m;
                    r_cneg  <= r_coef[COEF_W-1];
                    r_state <= S_DOT_D;
                end
                S_DOT_D: begin
                    r_norm <= r_norm + NORM_W'(r_pn[63:16]);
                    r_dot  <= r_dot + dot_part;
                    if (last_k) begin
                        r_state <= S_RES;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DOT_A;
                    end
                end

                S_RES: begin
                    r_k    <= '0;
                    r_rneg <= resid[R_W-1];
                    r_rmag <= resid[R_W-1] ? RM_W'(-resid) : RM_W'(resid);
                    if (r_norm == '0) begin
                        r_rstatus <= ST_ZERO_NORM;
                        r_state   <= S_OUT;
                    end else if (resid == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_UPD_A;
                    end
                end

                // Update pass: one divide and one read-modify-write per nonzero coefficient.
                // The write lands before the next read, so a repeated column sees its own update.
                S_UPD_A: r_state <= S_UPD_B;
                S_UPD_B: begin
                    r_col  <= buf_col;
                    r_cneg <= buf_coef[COEF_W-1];
                    r_plo  <= r_rmag[HALF-1:0] * buf_cm;
                    r_phi  <= r_rmag[RM_W-1:HALF] * buf_cm;
                    if (buf_cm == '0) begin
                        if (last_k) begin
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_UPD_A;
                        end
                    end else begin
                        r_state <= S_UPD_C;
                    end
                end
                S_UPD_C: begin
                    r_x     <= est_x;
                    r_word  <= est_rdata;
                    r_state <= S_UPD_D;
                end
                S_UPD_D: begin
                    if (div_done) begin
                        r_q     <= div_q;
                        r_state <= S_UPD_E;
                    end
                end
                S_UPD_E: begin
                    if (last_k) begin
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_UPD_A;
                    end
                end

                // Difference walk: read, square, accumulate, one element per cycle.
                S_SWEEP: begin
                    r_v1 <= (r_idx < r_len);
                    if (r_idx < r_len) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_v2 <= r_v1;
                    if (r_v1) begin
                        r_sq <= est_d2[2*EST_W-1:12];
                    end
                    if (r_v2) begin
                        r_acc <= acc_sum[63] ? '1 : acc_sum[DIFF_W-1:0];
                    end
                    if ((r_idx == r_len) && !r_v1 && !r_v2) begin
                        r_state <= S_SW_DEC;
                    end
                end

                // Plateau stop rule. Frozen once converged until a clear.
                S_SW_DEC: begin
                    r_idx   <= '0;
                    r_v1    <= 1'b0;
                    r_state <= S_OUT;
                    if (!r_done) begin
                        if (r_rec == '0) begin
                            if (r_sweeps > SWEEP_W'(r_min_sweeps)) begin
                                r_ref <= r_acc;
                                r_rec <= REC_W'(1);
                            end
                        end else if (r_acc < r_ref) begin
                            r_ref <= r_acc;
                            r_rec <= REC_W'(1);
                        end else begin
                            r_rec <= rec_inc;
                            if (rec_inc > {1'b0, r_plateau}) begin
                                r_done <= 1'b1;
                            end
                            r_state <= S_SNAP;
                        end
                    end
                end

                // Midpoint snapshot walk.
                S_SNAP: begin
                    r_v1 <= (r_idx < r_len);
                    if (r_idx < r_len) begin
                        r_idx <= r_idx + 1'b1;
                        r_a1  <= r_idx[AW-1:0];
                    end
                    if ((r_idx == r_len) && !r_v1) begin
                        r_state <= S_OUT;
                    end
                end

                S_RD_A: r_state <= S_RD_B;
                S_RD_B: begin
                    r_rsol  <= mid_rdata;
                    r_state <= S_OUT;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_osweeps, r_oconv, r_osol, r_odiff};
    assign m_axis_tuser  = r_ostatus;

    `BPK_NEVER(a_fill_range, r_fill > FW'(MAX_ROW_NONZEROS + 1))
    `BPK_NEVER(a_no_write_when_ready, est_we && s_axis_tready)
    `BPK_ASSERT(a_done_rule, $rose(r_done) |-> (r_rec > {1'b0, r_plateau}))

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the box-projected Kaczmarz engine.
// A sequence of directed requests comes first. Then come random phases, one for each setting
// of the three registers. A shadow copy of the estimates, the midpoint snapshot and the stop-rule
// state predicts every response. Responses are checked field by field, in order.
module testbench;
    import bpk_pkg::*;

    typedef struct packed {
        logic [1:0]  req;
        logic        sel;
        logic [11:0] col;
        logic [31:0] coef;
        logic [31:0] rhs;
        logic        last;
    } bpk_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [62:0] diff;
        logic [30:0] sol;
        logic        conv;
        logic [31:0] sweeps;
    } bpk_rsp_t;

    typedef struct {
        bpk_req_t r;
        bit       typed;
        bpk_rsp_t want;
    } dir_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [S_TUSER_W-1:0]  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    box_projected_kaczmarz_solver i_dut (.*);

    // The clock runs with a period of 8 ns.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // This is the shadow state of the engine.
    logic [30:0]        sh_down [4096];
    logic [30:0]        sh_up   [4096];
    logic [30:0]        sh_mid  [4096];
    logic [11:0]        sh_row_col  [64];
    logic signed [31:0] sh_row_coef [64];
    int unsigned        sh_fill;
    logic [31:0]        sh_sweeps;
    logic [63:0]        sh_ref;
    int unsigned        sh_rec;
    bit                 sh_done;
    int unsigned        cfg_min_sweeps;
    int unsigned        cfg_plateau;
    int unsigned        cfg_active;

    bpk_rsp_t  rsp_pending[$];
    dir_row_t  dir_tab[$];
    int        errors;
    bit        calm;

    function automatic longint unsigned magnitude(longint signed v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic int unsigned walk_span();
        return cfg_active > 4096 ? 4096 : cfg_active;
    endfunction

    // This function projects the selected estimate onto the row held in the buffers.
    // It returns the status of the row.
    function automatic logic [1:0] project_row(bit sel, int unsigned n, logic signed [31:0] rhs);
        longint unsigned norm, m, p, rmag, x, q;
        longint signed   dot, r;
        logic [127:0]    num, quot;
        int unsigned     k, c;
        norm = 0;
        dot = 0;
        for (k = 0; k < n; k++) begin
            m = magnitude(longint'(sh_row_coef[k]));
            x = sel ? sh_up[sh_row_col[k]] : sh_down[sh_row_col[k]];
            p = (m * x) >> 22;
            norm += (m * m) >> 16;
            dot += sh_row_coef[k] < 0 ? -longint'(p) : longint'(p);
        end
        if (norm == 0) return ST_ZERO_NORM;
        r = longint'(rhs) * 65536 - dot;
        rmag = magnitude(r);
        for (k = 0; k < n; k++) begin
            m = magnitude(longint'(sh_row_coef[k]));
            c = sh_row_col[k];
            if (m == 0 || rmag == 0) continue;
            num  = 128'(rmag) * 128'(m << 6);
            quot = num / 128'(norm);
            q = quot > 128'(64'h8000_0000) ? 64'h8000_0000 : quot[63:0];
            x = sel ? sh_up[c] : sh_down[c];
            if ((r < 0) != (sh_row_coef[k] < 0))
                x = q >= x ? 0 : x - q;
            else
                x = x + q > 64'h4000_0000 ? 64'h4000_0000 : x + q;
            if (sel) sh_up[c] = x[30:0];
            else     sh_down[c] = x[30:0];
        end
        return ST_OK;
    endfunction

    // This function closes a sweep. It returns the squared difference of the two estimates
    // and advances the plateau stop rule.
    function automatic logic [62:0] close_sweep();
        longint unsigned sum, d, t;
        int unsigned     i, span;
        span = walk_span();
        sum = 0;
        if (sh_sweeps != 32'hFFFF_FFFF) sh_sweeps++;
        for (i = 0; i < span; i++) begin
            d = sh_up[i] >= sh_down[i] ? sh_up[i] - sh_down[i] : sh_down[i] - sh_up[i];
            t = (d * d) >> 12;
            sum = sum > 64'h7FFF_FFFF_FFFF_FFFF - t ? 64'h7FFF_FFFF_FFFF_FFFF : sum + t;
        end
        if (!sh_done) begin
            if (sh_rec == 0) begin
                if (sh_sweeps > cfg_min_sweeps) begin
                    sh_ref = sum;
                    sh_rec = 1;
                end
            end else if (sum < sh_ref) begin
                sh_ref = sum;
                sh_rec = 1;
            end else begin
                if (sh_rec < 511) sh_rec++;
                for (i = 0; i < span; i++)
                    sh_mid[i] = (32'(sh_down[i]) + 32'(sh_up[i])) >> 1;
                if (sh_rec >= cfg_plateau + 1) sh_done = 1'b1;
            end
        end
        return sum[62:0];
    endfunction

    // This function advances the shadow state by one request and returns the response.
    function automatic bpk_rsp_t solver_step(bpk_req_t it);
        bpk_rsp_t    o;
        int unsigned n, i;
        o = '0;
        case (t_req'(it.req))
            REQ_NZ: begin
                if (sh_fill < 64) begin
                    sh_row_col[sh_fill]  = it.col;
                    sh_row_coef[sh_fill] = it.coef;
                    sh_fill++;
                end else begin
                    sh_fill = 65;
                end
                if (it.last) begin
                    n = sh_fill;
                    sh_fill = 0;
                    o.status = n > 64 ? ST_TOO_LONG : project_row(it.sel, n, it.rhs);
                end
            end
            REQ_SWEEP: o.diff = close_sweep();
            REQ_READ:  o.sol  = sh_mid[it.col];
            default: begin
                for (i = 0; i < walk_span(); i++) begin
                    sh_down[i] = '0;
                    sh_up[i]   = '0;
                    sh_mid[i]  = '0;
                end
                sh_fill = 0;
                sh_sweeps = '0;
                sh_ref = '0;
                sh_rec = 0;
                sh_done = 1'b0;
            end
        endcase
        o.conv   = sh_done;
        o.sweeps = sh_sweeps;
        return o;
    endfunction

    // This task sends one request. Once the request is accepted, it records the expected
    // response. The literal response is used when one is given. Otherwise the prediction is used.
    task automatic send_req(bpk_req_t it, bit typed = 1'b0, bpk_rsp_t want = '0);
        bpk_rsp_t pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.rhs, it.coef, it.col};
        s_axis_tuser  <= {it.sel, it.req};
        s_axis_tlast  <= it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = solver_step(it);
        rsp_pending.push_back(typed ? want : pred);
        if (!calm && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(t_cfg_idx idx, int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_SWEEPS: cfg_min_sweeps = value & 16'hFFFF;
            CFG_PLATEAU:    cfg_plateau    = value & 8'hFF;
            CFG_ACTIVE:     cfg_active     = value & 13'h1FFF;
            default: ;
        endcase
    endtask

    // This task waits until every response has arrived. It then waits for the slack that a long
    // walk of the engine can still need.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_dir(t_req req, bit sel, int unsigned col, logic [31:0] coef,
                           logic [31:0] rhs, bit last, bit typed = 1'b0,
                           bpk_rsp_t want = '0);
        dir_row_t d;
        d.r = '{req: req, sel: sel, col: col[11:0], coef: coef, rhs: rhs, last: last};
        d.typed = typed;
        d.want = want;
        dir_tab.push_back(d);
    endtask

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 99) < 20) return $urandom;
        if ($urandom_range(0, 99) < 5) return '0;
        return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    endfunction

    function automatic logic [31:0] rand_rhs();
        if ($urandom_range(0, 99) < 20) return $urandom;
        return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic logic [11:0] rand_col();
        if ($urandom_range(0, 99) < 15) return 12'($urandom);
        return 12'($urandom_range(0, walk_span() - 1));
    endfunction

    // This task sends one random phase. Most of it is well-formed rows closed by sweeps. Reads
    // of the midpoint, rare clears and now and then a row that is too long are mixed in.
    task automatic random_phase(int unsigned count);
        bpk_req_t    it;
        int unsigned sent, len, k, pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            it = '0;
            if (pick < 70) begin
                len = $urandom_range(0, 39) == 0 ? $urandom_range(65, 67)
                                                 : $urandom_range(1, 5);
                for (k = 0; k < len; k++) begin
                    it.req  = REQ_NZ;
                    it.sel  = $urandom_range(0, 1);
                    it.col  = rand_col();
                    it.coef = rand_coef();
                    it.rhs  = rand_rhs();
                    it.last = (k == len - 1);
                    send_req(it);
                end
                sent += len > 5 ? 5 : len;
            end else begin
                it.sel  = $urandom_range(0, 1);
                it.col  = rand_col();
                it.coef = $urandom;
                it.rhs  = $urandom;
                it.last = $urandom_range(0, 1);
                it.req  = pick < 84 ? REQ_SWEEP : pick < 97 ? REQ_READ : REQ_CLEAR;
                send_req(it);
                sent++;
            end
        end
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%t mismatch on %s: expected %0h, actual %0h", $realtime, name, want, got);
            errors++;
        end
    endtask

    // The response side stalls at random unless calm is set, and checks every response against
    // the oldest expectation.
    always @(posedge i_clk) begin
        bpk_rsp_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rsp_pending.size() == 0) begin
                $display("%t response with nothing expected: %h", $realtime, m_axis_tdata);
                errors++;
            end else begin
                want = rsp_pending.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("sweep_diff", want.diff, m_axis_tdata[62:0]);
                check_field("solution_value", want.sol, m_axis_tdata[93:63]);
                check_field("converged", want.conv, m_axis_tdata[94]);
                check_field("sweeps_done", want.sweeps, m_axis_tdata[126:95]);
            end
        end
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end

    initial begin
        int i;
        errors = 0;
        calm = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_MIN_SWEEPS;
        i_cfg_data    <= '0;
        for (i = 0; i < 4096; i++) begin
            sh_down[i] = '0;
            sh_up[i]   = '0;
            sh_mid[i]  = '0;
        end
        sh_fill = 0;
        sh_sweeps = '0;
        sh_ref = '0;
        sh_rec = 0;
        sh_done = 1'b0;
        cfg_min_sweeps = 0;
        cfg_plateau = 10;
        cfg_active = 4096;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the reset values of the registers. The expected response is
        // written in only for rows whose result is plain: reads after reset, the first sweep,
        // rows with zero norm and a clear.
        add_dir(REQ_READ, 0, 0, 0, 0, 0, 1, '0);
        add_dir(REQ_READ, 1, 4095, '1, '1, 1, 1, '0);
        add_dir(REQ_SWEEP, 0, 0, 0, 0, 0, 1, '{status: ST_OK, diff: 0, sol: 0, conv: 0, sweeps: 1});
        add_dir(REQ_NZ, 0, 3, 0, 0, 1, 1,
                '{status: ST_ZERO_NORM, diff: 0, sol: 0, conv: 0, sweeps: 1});
        // A coefficient this small truncates to zero once it is squared.
        add_dir(REQ_NZ, 1, 3, 1, 32'h7FFF_FFFF, 1, 1,
                '{status: ST_ZERO_NORM, diff: 0, sol: 0, conv: 0, sweeps: 1});
        add_dir(REQ_NZ, 0, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        // The same column appears twice in this row, with the most negative coefficient.
        add_dir(REQ_NZ, 0, 4095, 32'h8000_0000, 0, 0);
        add_dir(REQ_NZ, 1, 4095, 32'hFF00_0000, 32'h8000_0000, 1);
        add_dir(REQ_NZ, 0, 7, 32'h0100_0000, 32'h0001_0000, 1);
        add_dir(REQ_NZ, 1, 7, 32'h0080_0000, 32'h0000_8000, 1);
        add_dir(REQ_SWEEP, 0, 0, 0, 0, 0);
        // An open row stays pending across a sweep and a read.
        add_dir(REQ_NZ, 1, 9, 32'h0200_0000, 0, 0);
        add_dir(REQ_SWEEP, 1, 0, 0, 0, 1);
        add_dir(REQ_READ, 0, 5, 0, 0, 0);
        add_dir(REQ_NZ, 1, 10, 32'hFE00_0000, 32'hFFFE_0000, 1);
        add_dir(REQ_SWEEP, 0, 0, 0, 0, 0);
        add_dir(REQ_READ, 0, 7, 0, 0, 0);
        add_dir(REQ_READ, 0, 4095, 0, 0, 0);
        // A clear also throws away a row that is still open.
        add_dir(REQ_NZ, 0, 11, 32'h0100_0000, 0, 0);
        add_dir(REQ_CLEAR, 0, 0, 0, 0, 0, 1, '0);
        add_dir(REQ_NZ, 0, 12, 32'h0100_0000, 32'h0000_4000, 1);
        add_dir(REQ_SWEEP, 0, 0, 0, 0, 0);
        foreach (dir_tab[j]) send_req(dir_tab[j].r, dir_tab[j].typed, dir_tab[j].want);
        drain();

        // Random phases. The registers are rewritten only while the engine is idle. Among them are
        // minimum sweeps 0 and 65535, plateaus 1 and 255 and active columns 1 and 4096.
        cfg_write(CFG_MIN_SWEEPS, 0);
        cfg_write(CFG_PLATEAU, 1);
        cfg_write(CFG_ACTIVE, 1);
        random_phase(100);
        drain();

        calm = 1'b1;
        cfg_write(CFG_MIN_SWEEPS, 65535);
        cfg_write(CFG_PLATEAU, 255);
        cfg_write(CFG_ACTIVE, 4096);
        random_phase(80);
        drain();
        calm = 1'b0;

        cfg_write(CFG_MIN_SWEEPS, 2);
        cfg_write(CFG_PLATEAU, 3);
        cfg_write(CFG_ACTIVE, 16);
        random_phase(110);
        drain();

        cfg_write(CFG_MIN_SWEEPS, 1);
        cfg_write(CFG_PLATEAU, 2);
        cfg_write(CFG_ACTIVE, 64);
        random_phase(110);
        drain();
        repeat (100) @(posedge i_clk);

        if (errors == 0 && rsp_pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
